[hdl/i2crs_pkg.sv]
// ----------------------------------------------------------------------------
// I2C register access sequencer package
// Request and result payloads, engine commands, status and error codes.
// ----------------------------------------------------------------------------
package i2crs_pkg;

    localparam int unsigned KIND_W    = 2;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CMD_W     = 3;
    localparam int unsigned ERR_W     = 3;
    localparam int unsigned DEV_W     = 7;
    localparam int unsigned APB_DW    = 32;
    localparam int unsigned APB_AW    = 2;

    localparam logic [DEV_W-1:0]  DEV_ADDR_RESET = 7'd104;
    localparam logic [APB_AW-1:0] ADDR_DEVICE    = 2'd0;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EVENT = 2'd2;

    // engine status codes, upper five bits only
    localparam logic [BYTE_W-1:0] STATUS_MASK    = 8'hF8;
    localparam logic [BYTE_W-1:0] ST_START       = 8'h08;
    localparam logic [BYTE_W-1:0] ST_REP_START   = 8'h10;
    localparam logic [BYTE_W-1:0] ST_MT_SLA_ACK  = 8'h18;
    localparam logic [BYTE_W-1:0] ST_MT_SLA_NACK = 8'h20;
    localparam logic [BYTE_W-1:0] ST_MT_DATA_ACK = 8'h28;
    localparam logic [BYTE_W-1:0] ST_MR_SLA_ACK  = 8'h40;

    // engine commands
    localparam logic [CMD_W-1:0] CMD_NONE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SEND  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RXACK = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RXNAK = 3'd4;
    localparam logic [CMD_W-1:0] CMD_STOP  = 3'd5;

    // completion codes
    localparam logic [ERR_W-1:0] ERR_OK        = 3'd0;
    localparam logic [ERR_W-1:0] ERR_START     = 3'd1;
    localparam logic [ERR_W-1:0] ERR_SLA_BAD   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_NACK      = 3'd3;
    localparam logic [ERR_W-1:0] ERR_RESTART   = 3'd4;
    localparam logic [ERR_W-1:0] ERR_SLA_READ  = 3'd5;
    localparam logic [ERR_W-1:0] ERR_WRITE     = 3'd6;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] reg_address;
        logic [BYTE_W-1:0] write_data;
        logic [BYTE_W-1:0] byte_count;
        logic [BYTE_W-1:0] bus_status;
        logic [BYTE_W-1:0] rx_byte;
    } req_t;

    typedef struct packed {
        logic [CMD_W-1:0]  engine_cmd;
        logic [BYTE_W-1:0] tx_byte;
        logic [BYTE_W-1:0] read_byte;
        logic              read_valid;
        logic              done_res;
        logic [ERR_W-1:0]  error_code;
    } res_t;

    typedef enum logic [10:0] {
        PH_IDLE     = 11'b000_0000_0001,
        PH_R_START  = 11'b000_0000_0010,
        PH_R_SLAW   = 11'b000_0000_0100,
        PH_R_REG    = 11'b000_0000_1000,
        PH_R_RSTART = 11'b000_0001_0000,
        PH_R_SLAR   = 11'b000_0010_0000,
        PH_R_DATA   = 11'b000_0100_0000,
        PH_W_START  = 11'b000_1000_0000,
        PH_W_SLAW   = 11'b001_0000_0000,
        PH_W_REG    = 11'b010_0000_0000,
        PH_W_DATA   = 11'b100_0000_0000
    } phase_t;

endpackage

[hdl/i2crs_if.sv]
// ----------------------------------------------------------------------------
// I2C register access sequencer channels
// Valid/ready request and result channels with source and sink views.
// ----------------------------------------------------------------------------
interface i2crs_req_if;
    logic              valid;
    logic              ready;
    i2crs_pkg::req_t   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface i2crs_res_if;
    logic              valid;
    logic              ready;
    i2crs_pkg::res_t   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[hdl/i2c_register_access_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// I2C register access sequencer
// Turns register read/write requests and byte engine events into engine
// commands, received data and completion status.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one request per item. kind selects a register read, a register
//          write or a byte engine completion event; kind 3 is a no-op.
//   res  : exactly one result per request: the next engine command with
//          its byte, a received data byte, and done with an error code.
//   APB  : register 0 holds the 7-bit device address (reset 104). Write it
//          only while no transaction is running.
// Timing:
//   A request is taken into an input register, evaluated against the
//   sequencer state and lands in the result register. One request per
//   cycle is sustained while res is not held off, set by the single
//   state update per request.
// Reset:
//   rst_n clears the sequencer to idle and empties both registers.
// Stall:
//   While res is held off, the result register holds, the input register
//   fills, and req.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module i2c_register_access_sequencer_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    i2crs_req_if.sink                         req,
    i2crs_res_if.source                       res,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [i2crs_pkg::APB_AW-1:0]      paddr,
    input  logic [i2crs_pkg::APB_DW-1:0]      pwdata,
    output logic [i2crs_pkg::APB_DW-1:0]      prdata,
    output logic                              pready
);
    import i2crs_pkg::*;

    logic [DEV_W-1:0]  dev_addr_reg;
    req_t              in_reg;
    logic              in_valid_reg;
    res_t              res_reg;
    res_t              res_next;
    logic              res_valid_reg;
    phase_t            phase_reg;
    phase_t            phase_next;
    logic [BYTE_W-1:0] saved_register_reg;
    logic [BYTE_W-1:0] saved_register_next;
    logic [BYTE_W-1:0] saved_data_reg;
    logic [BYTE_W-1:0] saved_data_next;
    logic [BYTE_W-1:0] bytes_left_reg;
    logic [BYTE_W-1:0] bytes_left_next;

    logic              advance;
    logic              cfg_write;
    logic [BYTE_W-1:0] status;
    logic [BYTE_W-1:0] slaw;
    logic [BYTE_W-1:0] slar;
    logic [BYTE_W-1:0] left_dec;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg <= DEV_ADDR_RESET;
        end
        else if (cfg_write && (paddr == ADDR_DEVICE))
        begin
            dev_addr_reg <= pwdata[DEV_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_DEVICE)
        begin
            prdata = {{(APB_DW-DEV_W){1'b0}}, dev_addr_reg};
        end
    end

    // ------------------------------------------------------------------
    // handshake: input register feeds the result register
    // ------------------------------------------------------------------
    assign advance   = in_valid_reg && (!res_valid_reg || res.ready);
    assign req.ready = !in_valid_reg || advance;
    assign res.valid = res_valid_reg;
    assign res.payload = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_reg <= req.payload;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    // ------------------------------------------------------------------
    // sequencer state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            saved_register_reg <= '0;
            saved_data_reg     <= '0;
            bytes_left_reg     <= '0;
        end
        else if (advance)
        begin
            phase_reg          <= phase_next;
            saved_register_reg <= saved_register_next;
            saved_data_reg     <= saved_data_next;
            bytes_left_reg     <= bytes_left_next;
        end
    end

    assign status   = in_reg.bus_status & STATUS_MASK;
    assign slaw     = {dev_addr_reg, 1'b0};
    assign slar     = {dev_addr_reg, 1'b1};
    assign left_dec = bytes_left_reg - 8'd1;

    always_comb
    begin
        phase_next          = phase_reg;
        saved_register_next = saved_register_reg;
        saved_data_next     = saved_data_reg;
        bytes_left_next     = bytes_left_reg;
        res_next            = '0;

        if ((in_reg.kind == KIND_READ) || (in_reg.kind == KIND_WRITE))
        begin
            // requests while busy are dropped with an empty result
            if (phase_reg == PH_IDLE)
            begin
                saved_register_next = in_reg.reg_address;
                if (in_reg.kind == KIND_WRITE)
                begin
                    saved_data_next = in_reg.write_data;
                    phase_next      = PH_W_START;
                end
                else
                begin
                    bytes_left_next = in_reg.byte_count;
                    phase_next      = PH_R_START;
                end
                res_next.engine_cmd = CMD_START;
            end
        end
        else if (in_reg.kind == KIND_EVENT)
        begin
            unique case (phase_reg)
                PH_R_START:
                begin
                    if (status != ST_START)
                    begin
                        phase_next          = PH_IDLE;
                        res_next.done_res   = 1'b1;
                        res_next.error_code = ERR_START;
                    end
                    else
                    begin
                        phase_next          = PH_R_SLAW;
                        res_next.engine_cmd = CMD_SEND;
                        res_next.tx_byte    = slaw;
                    end
                end
                PH_R_SLAW:
                begin
                    if (status != ST_MT_SLA_ACK)
                    begin
                        phase_next          = PH_IDLE;
                        res_next.done_res   = 1'b1;
                        res_next.error_code = (status == ST_MT_SLA_NACK) ?
                                              ERR_NACK : ERR_SLA_BAD;
                    end
                    else
                    begin
                        phase_next          = PH_R_REG;
                        res_next.engine_cmd = CMD_SEND;
                        res_next.tx_byte    = saved_register_reg;
                    end
                end
                PH_R_REG:
                begin
                    if (status != ST_MT_DATA_ACK)
                    begin
                        phase_next          = PH_IDLE;
                        res_next.done_res   = 1'b1;
                        res_next.error_code = ERR_NACK;
                    end
                    else
                    begin
                        phase_next          = PH_R_RSTART;
                        res_next.engine_cmd = CMD_START;
                    end
                end
                PH_R_RSTART:
                begin
                    if (status != ST_REP_START)
                    begin
                        phase_next          = PH_IDLE;
                        res_next.done_res   = 1'b1;
                        res_next.error_code = ERR_RESTART;
                    end
                    else
                    begin
                        phase_next          = PH_R_SLAR;
                        res_next.engine_cmd = CMD_SEND;
                        res_next.tx_byte    = slar;
                    end
                end
                PH_R_SLAR:
                begin
                    if (status != ST_MR_SLA_ACK)
                    begin
                        phase_next          = PH_IDLE;
                        res_next.done_res   = 1'b1;
                        res_next.error_code = ERR_SLA_READ;
                    end
                    else if (bytes_left_reg == '0)
                    begin
                        // zero-length read: stop right away
                        phase_next          = PH_IDLE;
                        res_next.engine_cmd = CMD_STOP;
                        res_next.done_res   = 1'b1;
                    end
                    else
                    begin
                        phase_next          = PH_R_DATA;
                        res_next.engine_cmd = (bytes_left_reg > 8'd1) ?
                                              CMD_RXACK : CMD_RXNAK;
                    end
                end
                PH_R_DATA:
                begin
                    // no status check on received bytes
                    bytes_left_next     = left_dec;
                    res_next.read_byte  = in_reg.rx_byte;
                    res_next.read_valid = 1'b1;
                    if (left_dec == '0)
                    begin
                        phase_next          = PH_IDLE;
                        res_next.engine_cmd = CMD_STOP;
                        res_next.done_res   = 1'b1;
                    end
                    else
                    begin
                        res_next.engine_cmd = (left_dec > 8'd1) ?
                                              CMD_RXACK : CMD_RXNAK;
                    end
                end
                PH_W_START:
                begin
                    if (status != ST_START)
                    begin
                        phase_next          = PH_IDLE;
                        res_next.done_res   = 1'b1;
                        res_next.error_code = ERR_START;
                    end
                    else
                    begin
                        phase_next          = PH_W_SLAW;
                        res_next.engine_cmd = CMD_SEND;
                        res_next.tx_byte    = slaw;
                    end
                end
                PH_W_SLAW:
                begin
                    if (status != ST_MT_SLA_ACK)
                    begin
                        phase_next          = PH_IDLE;
                        res_next.done_res   = 1'b1;
                        res_next.error_code = ERR_WRITE;
                    end
                    else
                    begin
                        phase_next          = PH_W_REG;
                        res_next.engine_cmd = CMD_SEND;
                        res_next.tx_byte    = saved_register_reg;
                    end
                end
                PH_W_REG:
                begin
                    if (status != ST_MT_DATA_ACK)
                    begin
                        phase_next          = PH_IDLE;
                        res_next.done_res   = 1'b1;
                        res_next.error_code = ERR_WRITE;
                    end
                    else
                    begin
                        phase_next          = PH_W_DATA;
                        res_next.engine_cmd = CMD_SEND;
                        res_next.tx_byte    = saved_data_reg;
                    end
                end
                PH_W_DATA:
                begin
                    if (status != ST_MT_DATA_ACK)
                    begin
                        phase_next          = PH_IDLE;
                        res_next.done_res   = 1'b1;
                        res_next.error_code = ERR_WRITE;
                    end
                    else
                    begin
                        phase_next          = PH_IDLE;
                        res_next.engine_cmd = CMD_STOP;
                        res_next.done_res   = 1'b1;
                    end
                end
                default:
                begin
                    // idle: drop stray events
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_err_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.payload.done_res || (res.payload.error_code == ERR_OK)))
        else $error("error code reported without done");

    a_read_byte_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.payload.read_valid) |->
            ((res.payload.engine_cmd == CMD_RXACK) ||
             (res.payload.engine_cmd == CMD_RXNAK) ||
             (res.payload.engine_cmd == CMD_STOP)))
        else $error("received byte with unexpected engine command");

    a_tx_only_on_send: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && (res.payload.tx_byte != '0)) |->
            (res.payload.engine_cmd == CMD_SEND))
        else $error("tx byte set without send command");

    a_read_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_reg.kind == KIND_READ) && (phase_reg == PH_IDLE)) |=>
            ((phase_reg == PH_R_START) && res_valid_reg &&
             (res_reg.engine_cmd == CMD_START)))
        else $error("read request did not start a transaction");

endmodule
